// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is high.
`define GRD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/grd_pkg.sv -----
package grd_pkg;

  localparam int GRID_BYTES = 4096;
  localparam int GRID_AW    = 12;
  localparam int MAX_STEPS  = 128;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int RECIP_BITS = 31;
  localparam int RCNT_W     = $clog2(RECIP_BITS);
  localparam int DD_W       = 52;
  localparam int SD_W       = 60;
  localparam int PERP_W     = 48;
  localparam int MUL_A_W    = 36;
  localparam int MUL_B_W    = 16;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int CFG_AW     = 4;

  localparam logic [DD_W-1:0] DELTA_INF = DD_W'(1) << 51;
  localparam logic [SD_W-1:0] PERP_CAP  = SD_W'(1) << 47;

  localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [1:0] REG_CELL_STRIDE = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_RAY   = 1'b1;

  typedef enum logic [1:0] {
    MUL_SDX,
    MUL_SDY,
    MUL_ISX,
    MUL_ISY
  } mul_sel_t;

  typedef struct packed {
    logic [6:0] row_width;
    logic [6:0] row_count;
    logic [4:0] cell_stride;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     wr;
    mul_sel_t mul_sel;
    logic     ld_sdx;
    logic     ld_sdy;
    logic     step;
    logic     ld_idx;
    logic     rd;
    logic     chk;
    logic     ld_perp;
    logic     ld_isx;
    logic     ld_isy;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic div_idle;
    logic out_bounds;
    logic addr_over;
    logic wall;
    logic steps_max;
  } sts_t;

endpackage

// ----- design/grd_ifs.sv -----
interface grd_req_if (input logic clk);
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [11:0]        byte_addr;
  logic [7:0]         byte_value;
  logic [15:0]        start_x;
  logic [15:0]        start_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;

  modport source (output valid, req_type, byte_addr, byte_value, start_x, start_y,
                  dir_x, dir_y, input ready);
  modport sink (input valid, req_type, byte_addr, byte_value, start_x, start_y,
                dir_x, dir_y, output ready);
endinterface

interface grd_res_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        hit;
  logic        side;
  logic [5:0]  cell_x;
  logic [5:0]  cell_y;
  logic [31:0] perp_dist;
  logic [15:0] hit_x;
  logic [15:0] hit_y;

  modport source (output valid, hit, side, cell_x, cell_y, perp_dist, hit_x, hit_y,
                  input ready);
  modport sink (input valid, hit, side, cell_x, cell_y, perp_dist, hit_x, hit_y,
                output ready);
endinterface

// ----- design/grd_recip.sv -----
module grd_recip (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [grd_pkg::RECIP_BITS-1:0] quot
);
  import grd_pkg::*;

  logic [15:0]       dvs;
  logic [16:0]       rem;
  logic [RCNT_W-1:0] cnt;
  logic [16:0]       trial;
  logic              take;

  assign trial = {rem[15:0], (cnt == RCNT_W'(RECIP_BITS - 1))};
  assign take  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= RCNT_W'(RECIP_BITS - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= take ? (trial - {1'b0, dvs}) : trial;
      quot <= {quot[RECIP_BITS-2:0], take};
    end
  end
endmodule

// ----- design/grd_ctrl.sv -----
module grd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_type,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  grd_pkg::sts_t sts,
  output grd_pkg::cmd_t cmd
);
  import grd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SDX, S_SDY, S_SDW, S_STEP, S_IDX, S_ADDR, S_READ,
    S_PERP, S_ISX, S_ISY, S_ISW, S_FIN
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   fin_go;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_SDX;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.wr   = accept && (in_type == REQ_WRITE);
        cmd.load = accept && (in_type == REQ_RAY);
        if (cmd.load) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_idle) begin
          state_next = S_SDX;
        end
      end
      S_SDX: begin
        cmd.mul_sel = MUL_SDX;
        state_next  = S_SDY;
      end
      S_SDY: begin
        cmd.mul_sel = MUL_SDY;
        cmd.ld_sdx  = 1'b1;
        state_next  = S_SDW;
      end
      S_SDW: begin
        cmd.ld_sdy = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_IDX;
      end
      S_IDX: begin
        cmd.ld_idx = 1'b1;
        state_next = sts.out_bounds ? S_FIN : S_ADDR;
      end
      S_ADDR: begin
        cmd.rd     = !sts.addr_over;
        state_next = sts.addr_over ? S_FIN : S_READ;
      end
      S_READ: begin
        cmd.chk = 1'b1;
        if (sts.wall) begin
          state_next = S_PERP;
        end else if (sts.steps_max) begin
          state_next = S_FIN;
        end else begin
          state_next = S_STEP;
        end
      end
      S_PERP: begin
        cmd.ld_perp = 1'b1;
        state_next  = S_ISX;
      end
      S_ISX: begin
        cmd.mul_sel = MUL_ISX;
        state_next  = S_ISY;
      end
      S_ISY: begin
        cmd.mul_sel = MUL_ISY;
        cmd.ld_isx  = 1'b1;
        state_next  = S_ISW;
      end
      S_ISW: begin
        cmd.ld_isy = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.ld_out = fin_go;
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ----- design/grd_datapath.sv -----
module grd_datapath (
  input  logic          clk,
  input  logic          rst,
  input  grd_pkg::cfg_t cfg,
  input  grd_pkg::cmd_t cmd,
  output grd_pkg::sts_t sts,
  input  logic [11:0]        byte_addr,
  input  logic [7:0]         byte_value,
  input  logic [15:0]        start_x,
  input  logic [15:0]        start_y,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  output logic        hit,
  output logic        side,
  output logic [5:0]  cell_x,
  output logic [5:0]  cell_y,
  output logic [31:0] perp_dist,
  output logic [15:0] hit_x,
  output logic [15:0] hit_y
);
  import grd_pkg::*;

  logic [7:0] grid_mem [GRID_BYTES];
  logic [7:0] rd_data;

  logic [15:0] ox, oy, ax, ay;
  logic        negx, negy;
  logic [10:0] fx, fy;
  logic [15:0] in_ax, in_ay;
  logic        bx, by;
  logic [RECIP_BITS-1:0] qx, qy;
  logic [DD_W-1:0] ddx, ddy;
  logic [SD_W-1:0] sdx, sdy;
  logic signed [7:0] mx, my;
  logic        cur_side, hit_flag;
  logic [STEP_W-1:0] nsteps;
  logic [6:0]  w, h;
  logic [12:0] idx;
  logic [17:0] addr;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [SD_W-1:0]    diff;
  logic [PERP_W-1:0]  perp;
  logic [15:0] isx, isy;

  function automatic logic [15:0] isect(input logic [15:0] o, input logic neg,
                                        input logic zero, input logic big,
                                        input logic [31:0] disp);
    logic [33:0] r;
    r = neg ? ({18'b0, o} - {2'b0, disp}) : ({18'b0, o} + {2'b0, disp});
    if (zero) begin
      isect = o;
    end else if (big) begin
      isect = neg ? 16'h0000 : 16'hFFFF;
    end else if (neg) begin
      isect = r[33] ? 16'h0000 : r[15:0];
    end else begin
      isect = (r[33:16] != '0) ? 16'hFFFF : r[15:0];
    end
  endfunction

  assign in_ax = dir_x[15] ? 16'(-dir_x) : dir_x;
  assign in_ay = dir_y[15] ? 16'(-dir_y) : dir_y;

  grd_recip u_recip_x (.clk(clk), .rst(rst), .start(cmd.load), .divisor(in_ax),
                       .busy(bx), .quot(qx));
  grd_recip u_recip_y (.clk(clk), .rst(rst), .start(cmd.load), .divisor(in_ay),
                       .busy(by), .quot(qy));

  assign ddx = (ax == '0) ? DELTA_INF : DD_W'(qx);
  assign ddy = (ay == '0) ? DELTA_INF : DD_W'(qy);

  assign w = (cfg.row_width > 7'd64) ? 7'd64 : cfg.row_width;
  assign h = (cfg.row_count > 7'd64) ? 7'd64 : cfg.row_count;

  always_ff @(posedge clk) begin
    if (cmd.wr && ({4'b0, byte_addr} < 16'(GRID_BYTES))) begin
      grid_mem[byte_addr[GRID_AW-1:0]] <= byte_value;
    end
    if (cmd.rd) begin
      rd_data <= grid_mem[addr[GRID_AW-1:0]];
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_SDX: begin mul_a = ddx[MUL_A_W-1:0]; mul_b = {5'b0, fx}; end
      MUL_SDY: begin mul_a = ddy[MUL_A_W-1:0]; mul_b = {5'b0, fy}; end
      MUL_ISX: begin mul_a = perp[MUL_A_W-1:0]; mul_b = ax; end
      MUL_ISY: begin mul_a = perp[MUL_A_W-1:0]; mul_b = ay; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign diff = cur_side ? (sdy - SD_W'(ddy)) : (sdx - SD_W'(ddx));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load) begin
      ox   <= start_x;
      oy   <= start_y;
      ax   <= in_ax;
      ay   <= in_ay;
      negx <= dir_x[15];
      negy <= dir_y[15];
      fx   <= dir_x[15] ? {1'b0, start_x[9:0]} : (11'd1024 - {1'b0, start_x[9:0]});
      fy   <= dir_y[15] ? {1'b0, start_y[9:0]} : (11'd1024 - {1'b0, start_y[9:0]});
      mx   <= {2'b0, start_x[15:10]};
      my   <= {2'b0, start_y[15:10]};
    end
    if (cmd.ld_sdx) begin
      sdx <= (ax == '0) ? {8'b0, fx, 41'b0} : {18'b0, prod[PROD_W-1:10]};
    end
    if (cmd.ld_sdy) begin
      sdy <= (ay == '0) ? {8'b0, fy, 41'b0} : {18'b0, prod[PROD_W-1:10]};
    end
    if (cmd.step) begin
      if (sdx < sdy) begin
        sdx      <= sdx + SD_W'(ddx);
        mx       <= negx ? mx - 8'sd1 : mx + 8'sd1;
        cur_side <= 1'b0;
      end else begin
        sdy      <= sdy + SD_W'(ddy);
        my       <= negy ? my - 8'sd1 : my + 8'sd1;
        cur_side <= 1'b1;
      end
    end
    if (cmd.ld_idx) begin
      idx <= ({7'b0, my[5:0]} * {6'b0, w}) + {7'b0, mx[5:0]};
    end
    if (cmd.ld_perp) begin
      perp <= (diff > PERP_CAP) ? PERP_CAP[PERP_W-1:0] : diff[PERP_W-1:0];
    end
    if (cmd.ld_isx) begin
      isx <= isect(ox, negx, ax == '0, perp[PERP_W-1:36] != '0, prod[51:20]);
    end
    if (cmd.ld_isy) begin
      isy <= isect(oy, negy, ay == '0, perp[PERP_W-1:36] != '0, prod[51:20]);
    end
    if (cmd.ld_out) begin
      hit       <= hit_flag;
      side      <= hit_flag & cur_side;
      cell_x    <= hit_flag ? mx[5:0] : 6'd0;
      cell_y    <= hit_flag ? my[5:0] : 6'd0;
      perp_dist <= !hit_flag ? 32'd0 :
                   (perp[PERP_W-1:32] != '0) ? 32'hFFFF_FFFF : perp[31:0];
      hit_x     <= hit_flag ? isx : 16'd0;
      hit_y     <= hit_flag ? isy : 16'd0;
    end
  end

  assign addr = {5'b0, idx} * {13'b0, cfg.cell_stride};

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_flag <= 1'b0;
      nsteps   <= '0;
    end else begin
      if (cmd.load) begin
        hit_flag <= 1'b0;
        nsteps   <= '0;
      end else begin
        if (cmd.step) begin
          nsteps <= nsteps + 1'b1;
        end
        if (cmd.chk && sts.wall) begin
          hit_flag <= 1'b1;
        end
      end
    end
  end

  assign sts.div_idle   = !bx && !by;
  assign sts.out_bounds = mx[7] || my[7] || ({1'b0, mx[6:0]} >= {1'b0, w})
                          || ({1'b0, my[6:0]} >= {1'b0, h});
  assign sts.addr_over  = (addr >= 18'(GRID_BYTES));
  assign sts.wall       = (rd_data != 8'd0);
  assign sts.steps_max  = (nsteps == STEP_W'(MAX_STEPS));
endmodule

// ----- design/grid_ray_dda_traversal.sv -----
// Timing: a ray's result waits on N, the cells stepped (at most 128), and is set by the
// reciprocal units, which each form a 31-bit quotient, and by the step loop of states
// STEP, IDX, ADDR and READ that runs once per cell stepped.
// Throughput: one ray at a time; the next request is taken the cycle after the result is
// loaded, and writes are taken one per cycle while idle.
// Reset (synchronous, active high) clears control state and restores the registers;
// the grid store is not cleared and must be written before it is read.
module grid_ray_dda_traversal (
  input  logic        clk,
  input  logic        rst,
  grd_req_if.sink     req,
  grd_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [grd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import grd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width   <= 7'd64;
      cfg.row_count   <= 7'd64;
      cfg.cell_stride <= 5'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROW_WIDTH:   cfg.row_width   <= pwdata[6:0];
        REG_ROW_COUNT:   cfg.row_count   <= pwdata[6:0];
        REG_CELL_STRIDE: cfg.cell_stride <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROW_WIDTH:   prdata = {25'b0, cfg.row_width};
      REG_ROW_COUNT:   prdata = {25'b0, cfg.row_count};
      REG_CELL_STRIDE: prdata = {27'b0, cfg.cell_stride};
      default:         prdata = 32'd0;
    endcase
  end

  grd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_type(req.req_type), .in_ready(req.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .sts(sts), .cmd(cmd)
  );

  grd_datapath u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .sts(sts),
    .byte_addr(req.byte_addr), .byte_value(req.byte_value),
    .start_x(req.start_x), .start_y(req.start_y),
    .dir_x(req.dir_x), .dir_y(req.dir_y),
    .hit(res.hit), .side(res.side), .cell_x(res.cell_x), .cell_y(res.cell_y),
    .perp_dist(res.perp_dist), .hit_x(res.hit_x), .hit_y(res.hit_y)
  );
endmodule

// ----- design/grd_checker.sv -----
`include "assert_macros.svh"

module grd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic        side,
  input logic [5:0]  cell_x,
  input logic [5:0]  cell_y,
  input logic [31:0] perp_dist,
  input logic [15:0] hit_x,
  input logic [15:0] hit_y,
  input logic        pready
);
  `GRD_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `GRD_ASSERT(a_ray_busy, clk, rst, in_valid && in_ready && in_type |=> !in_ready, "ray overlap")
  `GRD_ASSERT(a_miss_zero, clk, rst, out_valid && !hit |-> !side && cell_x == 6'd0 && cell_y == 6'd0 && perp_dist == 32'd0 && hit_x == 16'd0 && hit_y == 16'd0, "miss not zero")
  `GRD_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")
endmodule

bind grid_ray_dda_traversal grd_checker u_grd_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready), .in_type(req.req_type),
  .out_valid(res.valid), .out_ready(res.ready), .hit(res.hit), .side(res.side),
  .cell_x(res.cell_x), .cell_y(res.cell_y), .perp_dist(res.perp_dist),
  .hit_x(res.hit_x), .hit_y(res.hit_y), .pready(pready)
);
